>>> hw/rtl/rfcab_pkg.sv
// shared types and constants of the rectangle fill / copy / blend blitter
`timescale 1ns / 1ps

package rfcab_pkg;

  // default sizes of the address and dimension counters
  localparam int unsigned ADDR_BITS_DEF = 20;
  localparam int unsigned DIM_BITS_DEF  = 10;

  // fixed field widths at the ports
  localparam int unsigned OUT_ADDR_W = 20;
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned DIM_CFG_W  = 10;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_IDX_W  = 3;

  // operating mode; the unused code behaves as copy
  typedef enum logic [1:0] {
    MODE_FILL  = 2'd0,
    MODE_COPY  = 2'd1,
    MODE_BLEND = 2'd2
  } mode_e;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE        = 3'd0,
    CFG_DEST_STRIDE = 3'd1,
    CFG_DEST_ORIGIN = 3'd2,
    CFG_SRC_STRIDE  = 3'd3,
    CFG_SRC_ORIGIN  = 3'd4,
    CFG_RECT_WIDTH  = 3'd5,
    CFG_RECT_HEIGHT = 3'd6,
    CFG_FILL_COLOR  = 3'd7
  } cfg_idx_e;

  // configuration register file contents
  typedef struct packed {
    mode_e                  mode;
    logic [DIM_CFG_W-1:0]   dest_stride;
    logic [OUT_ADDR_W-1:0]  dest_origin;
    logic [DIM_CFG_W-1:0]   src_stride;
    logic [OUT_ADDR_W-1:0]  src_origin;
    logic [DIM_CFG_W-1:0]   rect_width;
    logic [DIM_CFG_W-1:0]   rect_height;
    logic [PIX_W-1:0]       fill_color;
  } cfg_t;

  // one input request: fetched source and old destination pixel
  typedef struct packed {
    logic [PIX_W-1:0] src_pixel;
    logic [PIX_W-1:0] old_dest_pixel;
  } in_t;

  // one result: write address and pixel, next fetch addresses, last mark
  typedef struct packed {
    logic [OUT_ADDR_W-1:0] write_address;
    logic [PIX_W-1:0]      write_pixel;
    logic [OUT_ADDR_W-1:0] next_src_address;
    logic [OUT_ADDR_W-1:0] next_dest_address;
    logic                  last_pixel;
  } out_t;

endpackage

>>> hw/rtl/rect_fill_copy_alpha_blit_unit.sv
// top level of the rectangle fill / copy / blend blitter
`timescale 1ns / 1ps

// The blitter walks a rect_width by rect_height rectangle in raster order and
// takes one request per pixel (the fetched source pixel and the old destination
// pixel), returning one result per request: the destination write address, the
// pixel to write, the source and destination addresses to fetch next, and a
// mark on the last pixel. It sustains one pixel per clock unless the output
// stalls; a result passes the input register, then the result register, with
// the walk counters and the pixel arithmetic each one register stage deep.
// Output back-pressure stalls both stages in place. Any configuration write
// restarts the walk at the programmed origins; write registers only while no
// request is in flight.

module rect_fill_copy_alpha_blit_unit #(
  parameter int unsigned ADDR_BITS = rfcab_pkg::ADDR_BITS_DEF,
  parameter int unsigned DIM_BITS  = rfcab_pkg::DIM_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  rfcab_pkg::in_t                   in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output rfcab_pkg::out_t                  out_o,
  input  logic                             cfg_we_i,
  input  logic [rfcab_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rfcab_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  rfcab_pkg::cfg_t      cfg;
  logic                 restart;
  logic                 accept, advance, load_out;
  logic                 s1_valid_q, s1_valid_d, out_valid_q, out_valid_d;
  rfcab_pkg::in_t       s1_pix_q;
  logic [ADDR_BITS-1:0] s1_waddr, s1_sbase, s1_dbase;
  logic [DIM_BITS-1:0]  s1_col;
  logic                 s1_last;

  // handshake: stage 1 moves on whenever the result register is free or drained
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;
  assign load_out   = s1_valid_q && advance;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = s1_valid_q;
      s1_valid_d  = 1'b0;
    end
    if (accept) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input pixel register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q <= in_i;
    end
  end

  rfcab_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .restart_o   (restart)
  );

  rfcab_walk #(
    .ADDR_BITS (ADDR_BITS),
    .DIM_BITS  (DIM_BITS)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .restart_i   (restart),
    .step_i      (accept),
    .waddr_o     (s1_waddr),
    .src_base_o  (s1_sbase),
    .dest_base_o (s1_dbase),
    .col_o       (s1_col),
    .last_o      (s1_last)
  );

  rfcab_out #(
    .ADDR_BITS (ADDR_BITS),
    .DIM_BITS  (DIM_BITS)
  ) u_out (
    .clk_i       (clk_i),
    .load_i      (load_out),
    .cfg_i       (cfg),
    .pix_i       (s1_pix_q),
    .waddr_i     (s1_waddr),
    .src_base_i  (s1_sbase),
    .dest_base_i (s1_dbase),
    .col_i       (s1_col),
    .last_i      (s1_last),
    .res_o       (out_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/rfcab_cfg.sv
// configuration register file with restart pulse on every write
`timescale 1ns / 1ps

module rfcab_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rfcab_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rfcab_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output rfcab_pkg::cfg_t                      cfg_o,
  output logic                                 restart_o
);

  rfcab_pkg::cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (rfcab_pkg::cfg_idx_e'(cfg_idx_i))
        rfcab_pkg::CFG_MODE: begin
          cfg_d.mode = rfcab_pkg::mode_e'(cfg_wdata_i[1:0]);
        end
        rfcab_pkg::CFG_DEST_STRIDE: begin
          cfg_d.dest_stride = cfg_wdata_i[rfcab_pkg::DIM_CFG_W-1:0];
        end
        rfcab_pkg::CFG_DEST_ORIGIN: begin
          cfg_d.dest_origin = cfg_wdata_i[rfcab_pkg::OUT_ADDR_W-1:0];
        end
        rfcab_pkg::CFG_SRC_STRIDE: begin
          cfg_d.src_stride = cfg_wdata_i[rfcab_pkg::DIM_CFG_W-1:0];
        end
        rfcab_pkg::CFG_SRC_ORIGIN: begin
          cfg_d.src_origin = cfg_wdata_i[rfcab_pkg::OUT_ADDR_W-1:0];
        end
        rfcab_pkg::CFG_RECT_WIDTH: begin
          cfg_d.rect_width = cfg_wdata_i[rfcab_pkg::DIM_CFG_W-1:0];
        end
        rfcab_pkg::CFG_RECT_HEIGHT: begin
          cfg_d.rect_height = cfg_wdata_i[rfcab_pkg::DIM_CFG_W-1:0];
        end
        rfcab_pkg::CFG_FILL_COLOR: begin
          cfg_d.fill_color = cfg_wdata_i[rfcab_pkg::PIX_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  // register file, reset to a one-pixel fill at offset zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode        <= rfcab_pkg::MODE_FILL;
      cfg_q.dest_stride <= rfcab_pkg::DIM_CFG_W'(1);
      cfg_q.dest_origin <= '0;
      cfg_q.src_stride  <= rfcab_pkg::DIM_CFG_W'(1);
      cfg_q.src_origin  <= '0;
      cfg_q.rect_width  <= rfcab_pkg::DIM_CFG_W'(1);
      cfg_q.rect_height <= rfcab_pkg::DIM_CFG_W'(1);
      cfg_q.fill_color  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o     = cfg_q;
  // any write restarts the rectangle walk
  assign restart_o = cfg_we_i;

endmodule

>>> hw/rtl/rfcab_walk.sv
// raster walker: column / row counters, line bases and the stage-1 address record
`timescale 1ns / 1ps

module rfcab_walk #(
  parameter int unsigned ADDR_BITS = rfcab_pkg::ADDR_BITS_DEF,
  parameter int unsigned DIM_BITS  = rfcab_pkg::DIM_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rfcab_pkg::cfg_t       cfg_i,
  input  logic                  restart_i,
  input  logic                  step_i,
  output logic [ADDR_BITS-1:0]  waddr_o,
  output logic [ADDR_BITS-1:0]  src_base_o,
  output logic [ADDR_BITS-1:0]  dest_base_o,
  output logic [DIM_BITS-1:0]   col_o,
  output logic                  last_o
);

  localparam int unsigned CMP_W =
    (DIM_BITS + 1 > rfcab_pkg::DIM_CFG_W) ? DIM_BITS + 1 : rfcab_pkg::DIM_CFG_W;
  localparam int unsigned SUM_W = ((ADDR_BITS > DIM_BITS) ? ADDR_BITS : DIM_BITS) + 1;
  localparam int unsigned ORG_W =
    (ADDR_BITS > rfcab_pkg::OUT_ADDR_W) ? ADDR_BITS : rfcab_pkg::OUT_ADDR_W;

  logic [DIM_BITS-1:0]  col_q, col_d, row_q, row_d;
  logic [ADDR_BITS-1:0] dbase_q, dbase_d, sbase_q, sbase_d;
  logic                 restart_q;

  logic [DIM_BITS-1:0]  cur_col, cur_row;
  logic [ADDR_BITS-1:0] cur_dbase, cur_sbase, dorg, sorg;
  logic [ORG_W-1:0]     dorg_ext, sorg_ext;
  logic [CMP_W-1:0]     col_inc, row_inc;
  logic                 end_line, end_rect;
  logic [SUM_W-1:0]     waddr_sum;

  logic [ADDR_BITS-1:0] s1_waddr_q, s1_sbase_q, s1_dbase_q;
  logic [DIM_BITS-1:0]  s1_col_q;
  logic                 s1_last_q;

  // origins wrapped to the address width
  assign dorg_ext = ORG_W'(cfg_i.dest_origin);
  assign sorg_ext = ORG_W'(cfg_i.src_origin);
  assign dorg     = dorg_ext[ADDR_BITS-1:0];
  assign sorg     = sorg_ext[ADDR_BITS-1:0];

  // a pending restart makes the walk start from the origins
  assign cur_col   = restart_q ? '0 : col_q;
  assign cur_row   = restart_q ? '0 : row_q;
  assign cur_dbase = restart_q ? dorg : dbase_q;
  assign cur_sbase = restart_q ? sorg : sbase_q;

  // end of line and rectangle; a zero size behaves as one
  assign col_inc  = CMP_W'(cur_col) + CMP_W'(1);
  assign row_inc  = CMP_W'(cur_row) + CMP_W'(1);
  assign end_line = col_inc >= CMP_W'(cfg_i.rect_width);
  assign end_rect = end_line && (row_inc >= CMP_W'(cfg_i.rect_height));

  // destination write address of the current pixel
  assign waddr_sum = SUM_W'(cur_dbase) + SUM_W'(cur_col);

  // next walk position
  always_comb begin
    col_d   = col_inc[DIM_BITS-1:0];
    row_d   = cur_row;
    dbase_d = cur_dbase;
    sbase_d = cur_sbase;
    if (end_rect) begin
      col_d   = '0;
      row_d   = '0;
      dbase_d = dorg;
      sbase_d = sorg;
    end else if (end_line) begin
      col_d   = '0;
      row_d   = row_inc[DIM_BITS-1:0];
      dbase_d = cur_dbase + ADDR_BITS'(cfg_i.dest_stride);
      sbase_d = cur_sbase + ADDR_BITS'(cfg_i.src_stride);
    end
  end

  // walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      dbase_q   <= '0;
      sbase_q   <= '0;
      restart_q <= 1'b0;
    end else begin
      if (restart_i) begin
        restart_q <= 1'b1;
      end else if (step_i) begin
        restart_q <= 1'b0;
      end
      if (step_i) begin
        col_q   <= col_d;
        row_q   <= row_d;
        dbase_q <= dbase_d;
        sbase_q <= sbase_d;
      end
    end
  end

  // stage-1 address record of the accepted request
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      s1_waddr_q <= waddr_sum[ADDR_BITS-1:0];
      s1_sbase_q <= sbase_d;
      s1_dbase_q <= dbase_d;
      s1_col_q   <= col_d;
      s1_last_q  <= end_rect;
    end
  end

  assign waddr_o     = s1_waddr_q;
  assign src_base_o  = s1_sbase_q;
  assign dest_base_o = s1_dbase_q;
  assign col_o       = s1_col_q;
  assign last_o      = s1_last_q;

endmodule

>>> hw/rtl/rfcab_out.sv
// pixel path (fill, copy, argb4444 over rgb565 blend) and result register
`timescale 1ns / 1ps

module rfcab_out #(
  parameter int unsigned ADDR_BITS = rfcab_pkg::ADDR_BITS_DEF,
  parameter int unsigned DIM_BITS  = rfcab_pkg::DIM_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  load_i,
  input  rfcab_pkg::cfg_t       cfg_i,
  input  rfcab_pkg::in_t        pix_i,
  input  logic [ADDR_BITS-1:0]  waddr_i,
  input  logic [ADDR_BITS-1:0]  src_base_i,
  input  logic [ADDR_BITS-1:0]  dest_base_i,
  input  logic [DIM_BITS-1:0]   col_i,
  input  logic                  last_i,
  output rfcab_pkg::out_t       res_o
);

  localparam int unsigned SUM_W = ((ADDR_BITS > DIM_BITS) ? ADDR_BITS : DIM_BITS) + 1;
  localparam int unsigned ORG_W =
    (ADDR_BITS > rfcab_pkg::OUT_ADDR_W) ? ADDR_BITS : rfcab_pkg::OUT_ADDR_W;
  // x / 15 == (x * 2185) >> 15 for every x below 1024
  localparam int unsigned DIV15_MUL   = 2185;
  localparam int unsigned DIV15_SHIFT = 15;

  // divide a channel sum (at most 945) by 15
  function automatic logic [5:0] div15(input logic [9:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'(DIV15_MUL);
    return p[DIV15_SHIFT+5:DIV15_SHIFT];
  endfunction

  // argb4444 source over rgb565 destination
  function automatic logic [15:0] blend_px(input logic [15:0] s, input logic [15:0] d);
    logic [3:0] a, na;
    logic [8:0] r_num, b_num;
    logic [9:0] g_num;
    logic [5:0] r, g, b;
    a     = s[15:12];
    na    = 4'hf - a;
    r_num = 9'({s[11:8], 1'b0}) * 9'(a) + 9'(d[15:11]) * 9'(na);
    g_num = 10'({s[7:4], 2'b00}) * 10'(a) + 10'(d[10:5]) * 10'(na);
    b_num = 9'({s[3:0], 1'b0}) * 9'(a) + 9'(d[4:0]) * 9'(na);
    r     = div15(10'(r_num));
    g     = div15(g_num);
    b     = div15(10'(b_num));
    return {r[4:0], g, b[4:0]};
  endfunction

  logic [SUM_W-1:0]     nsrc_sum, ndest_sum;
  logic [ADDR_BITS-1:0] nsrc, ndest;
  logic [ORG_W-1:0]     waddr_ext, nsrc_ext, ndest_ext;
  logic [15:0]          pix;
  rfcab_pkg::out_t      res_d, res_q;

  // next fetch addresses from the new line bases and column
  assign nsrc_sum  = SUM_W'(src_base_i) + SUM_W'(col_i);
  assign ndest_sum = SUM_W'(dest_base_i) + SUM_W'(col_i);
  assign nsrc      = nsrc_sum[ADDR_BITS-1:0];
  assign ndest     = ndest_sum[ADDR_BITS-1:0];
  assign waddr_ext = ORG_W'(waddr_i);
  assign nsrc_ext  = ORG_W'(nsrc);
  assign ndest_ext = ORG_W'(ndest);

  // pixel select by mode; the spare code copies
  always_comb begin
    unique case (cfg_i.mode)
      rfcab_pkg::MODE_FILL:  pix = cfg_i.fill_color;
      rfcab_pkg::MODE_BLEND: pix = blend_px(pix_i.src_pixel, pix_i.old_dest_pixel);
      default:               pix = pix_i.src_pixel;
    endcase
  end

  // result assembly
  always_comb begin
    res_d.write_address     = waddr_ext[rfcab_pkg::OUT_ADDR_W-1:0];
    res_d.write_pixel       = pix;
    res_d.next_src_address  = nsrc_ext[rfcab_pkg::OUT_ADDR_W-1:0];
    res_d.next_dest_address = ndest_ext[rfcab_pkg::OUT_ADDR_W-1:0];
    res_d.last_pixel        = last_i;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

>>> hw/rtl/rfcab_chk.sv
// port-level checker for the blitter and its bind
`timescale 1ns / 1ps

module rfcab_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input rfcab_pkg::out_t                  out_o
);

  // a stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed or dropped");

  // with an empty result register the block must take a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("not ready while the output side is empty");

  // a fresh result follows an accepted request through stage 1 and the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result appeared without a matching request");

endmodule

bind rect_fill_copy_alpha_blit_unit rfcab_chk u_rfcab_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

>>> tb/rect_fill_copy_alpha_blit_unit_tb.sv
// testbench for the rectangle fill / copy / blend blitter: directed table, then random phases
`timescale 1ns / 1ps

module rect_fill_copy_alpha_blit_unit_tb;

  // run sizes and pressure points
  localparam int unsigned RANDOM_REQUESTS = 1250;
  localparam int unsigned QUIET_FROM      = 300;
  localparam int unsigned QUIET_TO        = 500;
  localparam int unsigned PAUSE_AT        = 700;
  localparam int unsigned HOLDOFF_AT      = 900;
  localparam int unsigned HOLDOFF_CYCLES  = 80;
  localparam int unsigned SETTLE_CYCLES   = 3;
  localparam logic [1:0]  MODE_SPARE      = 2'd3;

  // kinds of rows in the directed table
  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_PREDICTED,
    ROW_KNOWN
  } row_kind_e;

  typedef struct packed {
    row_kind_e                        kind;
    rfcab_pkg::cfg_idx_e              idx;
    logic [rfcab_pkg::CFG_DATA_W-1:0] wdata;
    rfcab_pkg::in_t                   px;
    rfcab_pkg::out_t                  want;
  } plan_row_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_ready_o;
  rfcab_pkg::in_t                   in_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  rfcab_pkg::out_t                  out_o;
  logic                             cfg_we_i;
  logic [rfcab_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [rfcab_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  rect_fill_copy_alpha_blit_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // shadow registers and walk state of the blitter
  logic [1:0]                       mode_q;
  logic [rfcab_pkg::DIM_CFG_W-1:0]  dest_stride_q, src_stride_q, width_q, height_q;
  logic [rfcab_pkg::OUT_ADDR_W-1:0] dest_origin_q, src_origin_q;
  logic [rfcab_pkg::PIX_W-1:0]      fill_q;
  logic [rfcab_pkg::DIM_CFG_W-1:0]  col_q, row_q;
  logic [rfcab_pkg::OUT_ADDR_W-1:0] dest_base_q, src_base_q;

  rfcab_pkg::out_t blit_writes_q[$];
  plan_row_t       plan[$];
  int unsigned     mismatches    = 0;
  int unsigned     results_seen  = 0;
  int unsigned     rect_ends     = 0;
  int unsigned     reg_writes    = 0;
  int unsigned     fill_reqs     = 0;
  int unsigned     copy_reqs     = 0;
  int unsigned     blend_reqs    = 0;
  bit              no_idle       = 1'b0;
  bit              holdoff_done  = 1'b0;

  // clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // walk back to the origins
  function automatic void rewind_walk();
    col_q       = '0;
    row_q       = '0;
    dest_base_q = dest_origin_q;
    src_base_q  = src_origin_q;
  endfunction

  function automatic void apply_reg_write(rfcab_pkg::cfg_idx_e idx,
                                          logic [rfcab_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      rfcab_pkg::CFG_MODE:        mode_q        = data[1:0];
      rfcab_pkg::CFG_DEST_STRIDE: dest_stride_q = data[rfcab_pkg::DIM_CFG_W-1:0];
      rfcab_pkg::CFG_DEST_ORIGIN: dest_origin_q = data[rfcab_pkg::OUT_ADDR_W-1:0];
      rfcab_pkg::CFG_SRC_STRIDE:  src_stride_q  = data[rfcab_pkg::DIM_CFG_W-1:0];
      rfcab_pkg::CFG_SRC_ORIGIN:  src_origin_q  = data[rfcab_pkg::OUT_ADDR_W-1:0];
      rfcab_pkg::CFG_RECT_WIDTH:  width_q       = data[rfcab_pkg::DIM_CFG_W-1:0];
      rfcab_pkg::CFG_RECT_HEIGHT: height_q      = data[rfcab_pkg::DIM_CFG_W-1:0];
      default:                    fill_q        = data[rfcab_pkg::PIX_W-1:0];
    endcase
    rewind_walk();
  endfunction

  // argb4444 source over rgb565 destination, truncating divide by 15
  function automatic logic [rfcab_pkg::PIX_W-1:0] argb4444_over_rgb565(
      logic [rfcab_pkg::PIX_W-1:0] s, logic [rfcab_pkg::PIX_W-1:0] d);
    int unsigned a, na, sr, sg, sb, dr, dg, db, r, g, b;
    a  = 32'(s[15:12]);
    na = 15 - a;
    sr = 32'(s[11:8]);
    sg = 32'(s[7:4]);
    sb = 32'(s[3:0]);
    dr = 32'(d[15:11]);
    dg = 32'(d[10:5]);
    db = 32'(d[4:0]);
    r  = ((sr << 1) * a + dr * na) / 15;
    g  = ((sg << 2) * a + dg * na) / 15;
    b  = ((sb << 1) * a + db * na) / 15;
    return {r[4:0], g[5:0], b[4:0]};
  endfunction

  // expected write for one request, advancing the raster walk
  function automatic rfcab_pkg::out_t compute_blit_write(rfcab_pkg::in_t px);
    rfcab_pkg::out_t res;
    logic end_line, end_rect;
    res.write_address = dest_base_q + rfcab_pkg::OUT_ADDR_W'(col_q);
    case (mode_q)
      rfcab_pkg::MODE_FILL: begin
        res.write_pixel = fill_q;
        fill_reqs++;
      end
      rfcab_pkg::MODE_BLEND: begin
        res.write_pixel = argb4444_over_rgb565(px.src_pixel, px.old_dest_pixel);
        blend_reqs++;
      end
      default: begin
        res.write_pixel = px.src_pixel;
        copy_reqs++;
      end
    endcase
    end_line = ({1'b0, col_q} + 11'd1) >= {1'b0, width_q};
    end_rect = end_line && (({1'b0, row_q} + 11'd1) >= {1'b0, height_q});
    if (end_rect) begin
      rewind_walk();
    end else if (end_line) begin
      col_q       = '0;
      row_q       = row_q + rfcab_pkg::DIM_CFG_W'(1);
      dest_base_q = dest_base_q + rfcab_pkg::OUT_ADDR_W'(dest_stride_q);
      src_base_q  = src_base_q + rfcab_pkg::OUT_ADDR_W'(src_stride_q);
    end else begin
      col_q = col_q + rfcab_pkg::DIM_CFG_W'(1);
    end
    res.next_src_address  = src_base_q + rfcab_pkg::OUT_ADDR_W'(col_q);
    res.next_dest_address = dest_base_q + rfcab_pkg::OUT_ADDR_W'(col_q);
    res.last_pixel        = end_rect;
    return res;
  endfunction

  // random register value, biased to extremes and small rectangles
  function automatic logic [rfcab_pkg::CFG_DATA_W-1:0] pick_reg_value(
      rfcab_pkg::cfg_idx_e idx);
    logic [rfcab_pkg::CFG_DATA_W-1:0] v;
    int unsigned field_w, pick;
    pick = $urandom_range(0, 19);
    case (idx)
      rfcab_pkg::CFG_MODE: begin
        field_w = 2;
        v = 20'($urandom_range(0, 3));
      end
      rfcab_pkg::CFG_DEST_STRIDE, rfcab_pkg::CFG_SRC_STRIDE: begin
        field_w = rfcab_pkg::DIM_CFG_W;
        if (pick == 0) v = '0;
        else if (pick == 1) v = 20'd1023;
        else if (pick < 8) v = 20'($urandom_range(1, 4));
        else v = 20'($urandom_range(1, 1023));
      end
      rfcab_pkg::CFG_DEST_ORIGIN, rfcab_pkg::CFG_SRC_ORIGIN: begin
        field_w = rfcab_pkg::OUT_ADDR_W;
        if (pick == 0) v = '0;
        else if (pick < 5) v = 20'hfffff - 20'($urandom_range(0, 16));
        else v = 20'($urandom);
      end
      rfcab_pkg::CFG_RECT_WIDTH: begin
        field_w = rfcab_pkg::DIM_CFG_W;
        if (pick == 0) v = '0;
        else if (pick == 1) v = 20'd1023;
        else v = 20'($urandom_range(1, 8));
      end
      rfcab_pkg::CFG_RECT_HEIGHT: begin
        field_w = rfcab_pkg::DIM_CFG_W;
        if (pick == 0) v = '0;
        else if (pick == 1) v = 20'd1023;
        else v = 20'($urandom_range(1, 6));
      end
      default: begin
        field_w = rfcab_pkg::PIX_W;
        v = 20'($urandom_range(0, 65535));
      end
    endcase
    // junk above the field must be dropped
    if (field_w < rfcab_pkg::CFG_DATA_W && $urandom_range(0, 3) == 0) begin
      v = v | (20'($urandom) << field_w);
    end
    return v;
  endfunction

  // directed table builders
  task automatic plan_write(rfcab_pkg::cfg_idx_e idx,
                            logic [rfcab_pkg::CFG_DATA_W-1:0] data);
    plan.push_back('{kind: ROW_WRITE, idx: idx, wdata: data, px: '0, want: '0});
  endtask

  task automatic plan_pixel(logic [rfcab_pkg::PIX_W-1:0] s, logic [rfcab_pkg::PIX_W-1:0] d);
    plan.push_back('{kind: ROW_PREDICTED, idx: rfcab_pkg::CFG_MODE, wdata: '0,
                     px: {s, d}, want: '0});
  endtask

  task automatic plan_known(logic [rfcab_pkg::PIX_W-1:0] s, logic [rfcab_pkg::PIX_W-1:0] d,
                            rfcab_pkg::out_t want);
    plan.push_back('{kind: ROW_KNOWN, idx: rfcab_pkg::CFG_MODE, wdata: '0,
                     px: {s, d}, want: want});
  endtask

  // drop valid and wait until every expected write has come back
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (blit_writes_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(rfcab_pkg::cfg_idx_e idx, logic [rfcab_pkg::CFG_DATA_W-1:0] data);
    settle_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    apply_reg_write(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
  endtask

  // offer one request; returns at the edge that accepted it
  task automatic offer_pixel(rfcab_pkg::in_t px, bit known, rfcab_pkg::out_t want);
    int unsigned     gap;
    bit              took;
    rfcab_pkg::out_t predicted;
    gap = 0;
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 15) gap++;
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= px;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    predicted = compute_blit_write(px);
    blit_writes_q.push_back(known ? want : predicted);
  endtask

  task automatic report_field(string name, logic [rfcab_pkg::OUT_ADDR_W-1:0] want,
                              logic [rfcab_pkg::OUT_ADDR_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result checker, sampled mid-cycle ahead of the accepting edge
  always @(negedge clk_i) begin
    rfcab_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (out_o.last_pixel) rect_ends++;
      if (blit_writes_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_o);
        mismatches++;
      end else begin
        want = blit_writes_q.pop_front();
        report_field("write_address", want.write_address, out_o.write_address);
        report_field("write_pixel", 20'(want.write_pixel), 20'(out_o.write_pixel));
        report_field("next_src_address", want.next_src_address, out_o.next_src_address);
        report_field("next_dest_address", want.next_dest_address, out_o.next_dest_address);
        report_field("last_pixel", 20'(want.last_pixel), 20'(out_o.last_pixel));
      end
    end
  end

  // result side: random stalls, one long hold-off while requests keep coming
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!holdoff_done && results_seen >= HOLDOFF_AT && in_valid_i) begin
        out_ready_i <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk_i);
        holdoff_done = 1'b1;
      end
      out_ready_i <= no_idle || ($urandom_range(0, 99) >= 15);
    end
  end

  // watchdog
  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned         random_sent, n_writes, n_reqs, w_eff, h_eff, area, k;
    rfcab_pkg::cfg_idx_e idx;
    rfcab_pkg::in_t      px;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_i        = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    mode_q        = rfcab_pkg::MODE_FILL;
    dest_stride_q = 10'd1;
    src_stride_q  = 10'd1;
    dest_origin_q = '0;
    src_origin_q  = '0;
    width_q       = 10'd1;
    height_q      = 10'd1;
    fill_q        = '0;
    rewind_walk();

    // directed table
    plan_known(16'hffff, 16'hffff, '{20'h0, 16'h0000, 20'h0, 20'h0, 1'b1});
    plan_write(rfcab_pkg::CFG_MODE, 20'(rfcab_pkg::MODE_COPY));
    plan_known(16'hffff, 16'h0000, '{20'h0, 16'hffff, 20'h0, 20'h0, 1'b1});
    plan_known(16'h0000, 16'hffff, '{20'h0, 16'h0000, 20'h0, 20'h0, 1'b1});
    plan_write(rfcab_pkg::CFG_MODE, 20'(rfcab_pkg::MODE_BLEND));
    // opaque white source, transparent source, opaque black source
    plan_known(16'hffff, 16'h0000, '{20'h0, 16'hf79e, 20'h0, 20'h0, 1'b1});
    plan_known(16'h0fff, 16'hffff, '{20'h0, 16'hffff, 20'h0, 20'h0, 1'b1});
    plan_known(16'hf000, 16'hffff, '{20'h0, 16'h0000, 20'h0, 20'h0, 1'b1});
    plan_pixel(16'h8a5c, 16'h1234);
    plan_pixel(16'h73c9, 16'ha5f0);
    // spare mode code acts as copy
    plan_write(rfcab_pkg::CFG_MODE, 20'(MODE_SPARE));
    plan_known(16'habcd, 16'h0000, '{20'h0, 16'habcd, 20'h0, 20'h0, 1'b1});
    plan_write(rfcab_pkg::CFG_FILL_COLOR, 20'hfffff);
    plan_write(rfcab_pkg::CFG_MODE, 20'(rfcab_pkg::MODE_FILL));
    plan_known(16'h1234, 16'h5678, '{20'h0, 16'hffff, 20'h0, 20'h0, 1'b1});
    // destination wraps past the top, source stride of zero
    plan_write(rfcab_pkg::CFG_MODE, 20'(rfcab_pkg::MODE_COPY));
    plan_write(rfcab_pkg::CFG_DEST_STRIDE, 20'd1023);
    plan_write(rfcab_pkg::CFG_DEST_ORIGIN, 20'hfffff);
    plan_write(rfcab_pkg::CFG_SRC_STRIDE, 20'd0);
    plan_write(rfcab_pkg::CFG_SRC_ORIGIN, 20'h12345);
    plan_write(rfcab_pkg::CFG_RECT_WIDTH, 20'd2);
    plan_write(rfcab_pkg::CFG_RECT_HEIGHT, 20'd2);
    plan_pixel(16'h0001, 16'hfffe);
    plan_pixel(16'h8000, 16'h7fff);
    plan_pixel(16'h5555, 16'haaaa);
    plan_pixel(16'haaaa, 16'h5555);
    // zero width and height behave as one
    plan_write(rfcab_pkg::CFG_RECT_WIDTH, 20'd0);
    plan_write(rfcab_pkg::CFG_RECT_HEIGHT, 20'd0);
    plan_write(rfcab_pkg::CFG_DEST_ORIGIN, 20'h0);
    plan_write(rfcab_pkg::CFG_SRC_ORIGIN, 20'hfffff);
    plan_known(16'h0001, 16'h0000, '{20'h0, 16'h0001, 20'hfffff, 20'h0, 1'b1});
    // largest rectangle and source stride, walk cut short by a write
    plan_write(rfcab_pkg::CFG_RECT_WIDTH, 20'd1023);
    plan_write(rfcab_pkg::CFG_RECT_HEIGHT, 20'd1023);
    plan_write(rfcab_pkg::CFG_SRC_STRIDE, 20'd1023);
    plan_write(rfcab_pkg::CFG_DEST_STRIDE, 20'd1);
    plan_pixel(16'hfedc, 16'h0123);
    plan_pixel(16'h0f0f, 16'hf0f0);
    plan_pixel(16'h3c3c, 16'hc3c3);
    plan_write(rfcab_pkg::CFG_SRC_ORIGIN, 20'h0);
    plan_pixel(16'h1111, 16'heeee);
    plan_pixel(16'heeee, 16'h1111);
    plan_write(rfcab_pkg::CFG_MODE, 20'(rfcab_pkg::MODE_BLEND));
    plan_write(rfcab_pkg::CFG_RECT_WIDTH, 20'd3);
    plan_write(rfcab_pkg::CFG_RECT_HEIGHT, 20'd1);
    plan_pixel(16'hf0f0, 16'h0f0f);
    plan_pixel(16'h1111, 16'heeee);
    plan_pixel(16'h7777, 16'h8888);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) write_reg(plan[i].idx, plan[i].wdata);
      else offer_pixel(plan[i].px, plan[i].kind == ROW_KNOWN, plan[i].want);
    end

    // random phases: a few register writes, then whole or partial rectangles
    random_sent = 0;
    while (random_sent < RANDOM_REQUESTS) begin
      n_writes = $urandom_range(1, 3);
      repeat (n_writes) begin
        idx = rfcab_pkg::cfg_idx_e'($urandom_range(0, 7));
        write_reg(idx, pick_reg_value(idx));
      end
      w_eff = (width_q == 0) ? 1 : 32'(width_q);
      h_eff = (height_q == 0) ? 1 : 32'(height_q);
      area  = w_eff * h_eff;
      if (area <= 48) begin
        if ($urandom_range(0, 5) == 0) n_reqs = $urandom_range(1, area);
        else n_reqs = area * $urandom_range(1, 3);
      end else begin
        n_reqs = $urandom_range(4, 40);
      end
      for (k = 0; k < n_reqs; k++) begin
        if (random_sent == PAUSE_AT) settle_idle();
        no_idle = (random_sent >= QUIET_FROM) && (random_sent < QUIET_TO);
        px = rfcab_pkg::in_t'($urandom);
        // push alpha to its extremes now and then
        case ($urandom_range(0, 7))
          0: px.src_pixel[15:12] = 4'h0;
          1: px.src_pixel[15:12] = 4'hf;
          default: ;
        endcase
        offer_pixel(px, 1'b0, '0);
        random_sent++;
      end
    end
    no_idle = 1'b0;

    // drain and close
    in_valid_i <= 1'b0;
    while (blit_writes_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("run covered %0d requests (fill %0d, copy %0d, blend %0d), %0d register writes",
             fill_reqs + copy_reqs + blend_reqs, fill_reqs, copy_reqs, blend_reqs, reg_writes);
    $display("%0d results checked, %0d rectangle ends, %0d mismatches",
             results_seen, rect_ends, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
